[hdl/rqwr_pkg.sv]
`default_nettype none

package rqwr_pkg;

   localparam logic [1:0] OP_ADD       = 2'd0;
   localparam logic [1:0] OP_YIELD     = 2'd1;
   localparam logic [1:0] OP_TERMINATE = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] thread_id;
   } req_type;

   typedef struct packed {
      logic       dispatch_valid;
      logic [7:0] dispatch_id;
      logic       removed;
      logic [1:0] status;
      logic [4:0] occupancy;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctl_cmd_type;

endpackage

`default_nettype wire

[hdl/rqwr_ctrl.sv]
`default_nettype none

module rqwr_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   output rqwr_pkg::ctl_cmd_type cmd
);
   import rqwr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept      = start && (state_ff == ST_IDLE);
   assign busy        = (state_ff == ST_UPDATE);
   assign cmd.capture = accept;
   assign cmd.commit  = (state_ff == ST_UPDATE);

   always_comb begin
      unique case (state_ff)
         ST_IDLE:   state_in = accept ? ST_UPDATE : ST_IDLE;
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[hdl/rqwr_datapath.sv]
`default_nettype none

module rqwr_datapath #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  wire                   clock,
   input  wire                   reset,
   input  rqwr_pkg::ctl_cmd_type cmd,
   input  rqwr_pkg::req_type     req_payload,
   output logic                  rsp_valid,
   output rqwr_pkg::rsp_type     rsp_payload
);
   import rqwr_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [ID_BITS-1:0]     slots_ff [QUEUE_DEPTH];
   logic [ID_BITS-1:0]     slots_in [QUEUE_DEPTH];
   logic [ID_BITS-1:0]     lp       [QUEUE_DEPTH];
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [CNT_W-1:0]       lcount;
   logic [1:0]             op_ff;
   logic [ID_BITS-1:0]     id_hold_ff;
   logic [QUEUE_DEPTH-1:0] match_ff;
   logic [QUEUE_DEPTH-1:0] match_in;
   logic [QUEUE_DEPTH-1:0] sfx;
   logic [QUEUE_DEPTH-1:0] above;
   logic                   found;
   logic                   removing;
   logic [ID_BITS+7:0]     id_wide;
   logic [ID_BITS-1:0]     id;
   logic [ID_BITS+7:0]     head_wide;
   logic [CNT_W+4:0]       occ_wide;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;
   logic                   rsp_valid_ff;

   assign id_wide   = {{ID_BITS{1'b0}}, req_payload.thread_id};
   assign id        = id_wide[ID_BITS-1:0];
   assign head_wide = {8'b0, lp[0]};

   always_comb begin
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
         match_in[j] = (CNT_W'(j) < count_ff) && (slots_ff[j] == id);
      end
   end

   // Newest match is the one with no match above it.
   always_comb begin
      sfx = match_ff;
      for (int d = 1; d < QUEUE_DEPTH; d = d * 2) begin
         sfx = sfx | (sfx >> d);
      end
      above    = sfx >> 1;
      found    = sfx[0];
      removing = (op_ff == OP_TERMINATE) && found;
      for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
         lp[j] = (removing && !above[j]) ? slots_ff[j+1] : slots_ff[j];
      end
      lp[QUEUE_DEPTH-1] = slots_ff[QUEUE_DEPTH-1];
      lcount = count_ff - CNT_W'(removing);
   end

   always_comb begin
      slots_in = slots_ff;
      count_in = count_ff;
      rsp_in   = '0;
      unique case (op_ff)
         OP_ADD: begin
            if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
               rsp_in.status = STATUS_FULL;
            end else begin
               for (int j = 0; j < QUEUE_DEPTH; j++) begin
                  if (CNT_W'(j) == count_ff) begin
                     slots_in[j] = id_hold_ff;
                  end
               end
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_YIELD, OP_TERMINATE: begin
            rsp_in.removed = removing;
            if (lcount != '0) begin
               rsp_in.dispatch_valid = 1'b1;
               rsp_in.dispatch_id    = head_wide[7:0];
               rsp_in.status         = STATUS_OK;
               count_in              = lcount - CNT_W'(1);
               for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
                  slots_in[j] = lp[j+1];
               end
               slots_in[QUEUE_DEPTH-1] = lp[QUEUE_DEPTH-1];
            end else begin
               rsp_in.status = STATUS_EMPTY;
               count_in      = lcount;
               slots_in      = lp;
            end
         end
         default: begin
         end
      endcase
      occ_wide         = {5'b0, count_in};
      rsp_in.occupancy = occ_wide[4:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_payload.op;
         id_hold_ff <= id;
         match_ff   <= match_in;
      end
      if (cmd.commit) begin
         slots_ff <= slots_in;
         rsp_ff   <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= cmd.commit;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

[hdl/ready_queue_with_removal.sv]
`default_nettype none

// Channel   Ports                      Handshake
// request   start, busy, req_payload   beat taken when start is high and busy is low
// response  rsp_valid, rsp_payload     beat shown for one cycle, always taken
//
// Each operation has an accept cycle, which compares the identifier against
// every stored entry in parallel, and an update cycle, which shifts the entry cells.
// The response appears in the cycle after the update, when the next beat may
// already be accepted; no new beat is taken while the update is under way.
// Synchronous reset empties the queue; the entry cells themselves are not cleared.
// The receiver cannot stall the response.

module ready_queue_with_removal #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  rqwr_pkg::req_type  req_payload,
   output logic               rsp_valid,
   output rqwr_pkg::rsp_type  rsp_payload
);
   import rqwr_pkg::*;

   ctl_cmd_type cmd;

   rqwr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   rqwr_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted beat did not start an update");

   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid && !busy)
      else $error("update did not produce a response beat");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && !$past(rsp_valid))
      else $error("response beat outside its slot");

   a_full_nopop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STATUS_FULL
      |-> !rsp_payload.dispatch_valid && !rsp_payload.removed)
      else $error("dropped add reported a dispatch or removal");

endmodule

`default_nettype wire

[verif/ready_queue_with_removal_test.sv]
`default_nettype none

module ready_queue_with_removal_test;
   import rqwr_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int ITEM_COUNT = 1950;
   localparam int BLOCK_ITEMS = 50;
   localparam logic [1:0] OP_NONE = 2'd3;

   typedef struct {
      req_type req;
      int      repeats;
      bit      fixed;
      rsp_type rsp;
   } stim_row_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_payload = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_payload;

   logic [7:0] ready_ids [QUEUE_DEPTH];
   int         ready_count = 0;
   rsp_type    pending_rsp [$];

   int error_count = 0;
   int checked_count = 0;
   int sent_count = 0;
   int full_count = 0;
   int empty_count = 0;
   int removed_count = 0;
   int dispatch_count = 0;

   stim_row_type directed_rows [13] = '{
      '{'{OP_YIELD, 8'h00}, 1, 1'b1, '{1'b0, 8'h00, 1'b0, STATUS_EMPTY, 5'd0}},
      '{'{OP_TERMINATE, 8'h55}, 1, 1'b1, '{1'b0, 8'h00, 1'b0, STATUS_EMPTY, 5'd0}},
      '{'{OP_NONE, 8'hFF}, 1, 1'b1, '{1'b0, 8'h00, 1'b0, STATUS_OK, 5'd0}},
      '{'{OP_ADD, 8'h00}, 1, 1'b1, '{1'b0, 8'h00, 1'b0, STATUS_OK, 5'd1}},
      '{'{OP_YIELD, 8'h00}, 1, 1'b1, '{1'b1, 8'h00, 1'b0, STATUS_OK, 5'd0}},
      '{'{OP_ADD, 8'hFF}, 1, 1'b1, '{1'b0, 8'h00, 1'b0, STATUS_OK, 5'd1}},
      '{'{OP_ADD, 8'h20}, 14, 1'b0, '0},
      '{'{OP_ADD, 8'h20}, 1, 1'b0, '0},
      '{'{OP_ADD, 8'hAA}, 1, 1'b1, '{1'b0, 8'h00, 1'b0, STATUS_FULL, 5'd16}},
      '{'{OP_NONE, 8'h00}, 1, 1'b0, '0},
      '{'{OP_TERMINATE, 8'h20}, 1, 1'b0, '0},
      '{'{OP_TERMINATE, 8'h99}, 1, 1'b0, '0},
      '{'{OP_YIELD, 8'h00}, 1, 1'b0, '0}
   };

   ready_queue_with_removal dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("%s", msg);
      end
   endfunction

   function automatic rsp_type pop_ready_head(input rsp_type res);
      if (ready_count == 0) begin
         res.dispatch_valid = 1'b0;
         res.dispatch_id = 8'h00;
         res.status = STATUS_EMPTY;
      end else begin
         res.dispatch_valid = 1'b1;
         res.dispatch_id = ready_ids[0];
         res.status = STATUS_OK;
         for (int i = 1; i < ready_count; i++) begin
            ready_ids[i - 1] = ready_ids[i];
         end
         ready_count--;
      end
      return res;
   endfunction

   function automatic rsp_type schedule_op(input req_type r);
      rsp_type res;
      int      hit;
      res = '0;
      case (r.op)
         OP_ADD: begin
            if (ready_count >= QUEUE_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               ready_ids[ready_count] = r.thread_id;
               ready_count++;
            end
         end
         OP_YIELD: begin
            res = pop_ready_head(res);
         end
         OP_TERMINATE: begin
            hit = -1;
            for (int i = ready_count - 1; i >= 0; i--) begin
               if (hit < 0 && ready_ids[i] == r.thread_id) begin
                  hit = i;
               end
            end
            if (hit >= 0) begin
               for (int k = hit + 1; k < ready_count; k++) begin
                  ready_ids[k - 1] = ready_ids[k];
               end
               ready_count--;
               res.removed = 1'b1;
            end
            res = pop_ready_head(res);
         end
         default: begin
         end
      endcase
      res.occupancy = 5'(ready_count);
      return res;
   endfunction

   function automatic logic [7:0] pick_thread_id(input int present_pct);
      if (ready_count > 0 && $urandom_range(0, 99) < present_pct) begin
         return ready_ids[$urandom_range(0, ready_count - 1)];
      end else if ($urandom_range(0, 2) == 0) begin
         return 8'($urandom_range(0, 15));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_beat(input req_type r, input int gap, input bit fixed,
                            input rsp_type fixed_rsp);
      rsp_type predicted;
      repeat (gap) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = schedule_op(r);
      pending_rsp.push_back(fixed ? fixed_rsp : predicted);
      sent_count++;
      if (predicted.status == STATUS_FULL) full_count++;
      if (predicted.status == STATUS_EMPTY) empty_count++;
      if (predicted.removed) removed_count++;
      if (predicted.dispatch_valid) dispatch_count++;
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_rsp.size() != 0) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            note_error($sformatf("result beat with nothing expected: %p", rsp_payload));
         end else begin
            want = pending_rsp.pop_front();
            checked_count++;
            if (rsp_payload.dispatch_valid !== want.dispatch_valid ||
                rsp_payload.dispatch_id !== want.dispatch_id ||
                rsp_payload.removed !== want.removed ||
                rsp_payload.status !== want.status ||
                rsp_payload.occupancy !== want.occupancy) begin
               note_error($sformatf(
                  {"result %0d: expected valid=%0d id=%02h removed=%0d status=%0d occ=%0d,",
                   " got valid=%0d id=%02h removed=%0d status=%0d occ=%0d"},
                  checked_count, want.dispatch_valid, want.dispatch_id, want.removed,
                  want.status, want.occupancy, rsp_payload.dispatch_valid,
                  rsp_payload.dispatch_id, rsp_payload.removed, rsp_payload.status,
                  rsp_payload.occupancy));
            end
         end
      end
   end

   initial begin : stimulus
      req_type r;
      int      add_pct;
      int      term_pct;
      int      present_pct;
      int      pick;
      int      gap;
      bit      burst;
      int      waited;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n]) begin
         for (int k = 0; k < directed_rows[n].repeats; k++) begin
            r = directed_rows[n].req;
            r.thread_id = r.thread_id + 8'(k);
            send_beat(r, $urandom_range(0, 14), directed_rows[n].fixed, directed_rows[n].rsp);
         end
      end
      wait_for_drain();

      for (int blk = 0; blk < ITEM_COUNT / BLOCK_ITEMS; blk++) begin
         case ($urandom_range(0, 3))
            0: begin add_pct = 75; term_pct = 40; end
            1: begin add_pct = 25; term_pct = 40; end
            2: begin add_pct = 48; term_pct = 50; end
            default: begin add_pct = 55; term_pct = 85; end
         endcase
         present_pct = $urandom_range(30, 90);
         burst = ($urandom_range(0, 3) == 0);
         if (blk == 20) begin
            wait_for_drain();
         end
         for (int i = 0; i < BLOCK_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               r.op = OP_NONE;
               r.thread_id = 8'($urandom_range(0, 255));
            end else if (pick < 3 + add_pct) begin
               r.op = OP_ADD;
               r.thread_id = pick_thread_id(15);
            end else if ($urandom_range(0, 99) < term_pct) begin
               r.op = OP_TERMINATE;
               r.thread_id = pick_thread_id(present_pct);
            end else begin
               r.op = OP_YIELD;
               r.thread_id = 8'($urandom_range(0, 255));
            end
            gap = burst ? 0 : $urandom_range(0, 14);
            send_beat(r, gap, 1'b0, '0);
         end
      end
      start <= 1'b0;

      for (waited = 0; pending_rsp.size() != 0 && waited < 2000; waited++) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         note_error($sformatf("%0d expected results never arrived", pending_rsp.size()));
      end

      $display("Sent %0d operations and checked %0d results, %0d mismatches.",
               sent_count, checked_count, error_count);
      $display("Covered %0d dispatches, %0d removals, %0d empty pops and %0d full adds.",
               dispatch_count, removed_count, empty_count, full_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
